// ===== rtl/hpa_pkg.sv =====
package hpa_pkg;

  localparam int unsigned LENGTH_WIDTH       = 48;
  localparam logic [31:0] DEFAULT_PAGE_BYTES = 32'd2097152;

  localparam int unsigned TIME_WIDTH      = 64;
  localparam int unsigned BUDGET_WIDTH    = 32;
  localparam int unsigned KB_WIDTH        = 22;
  localparam int unsigned KB_SHIFT        = 10;
  localparam int unsigned PAGE_WIDTH      = KB_WIDTH + KB_SHIFT;
  localparam int unsigned CMD_WIDTH       = 2;
  localparam int unsigned MODE_WIDTH      = 2;
  localparam int unsigned CFG_INDEX_WIDTH = 2;
  localparam int unsigned CFG_DATA_WIDTH  = 64;

  localparam logic [TIME_WIDTH-1:0] REFRESH_COOLDOWN_RESET = 64'd1000000000;
  localparam logic [TIME_WIDTH-1:0] FAILURE_COOLDOWN_RESET = 64'd2000000000;

  // Command codes carried by each input transfer.
  localparam logic [CMD_WIDTH-1:0] CMD_QUERY   = 2'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_SUCCESS = 2'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_FAILURE = 2'd2;
  localparam logic [CMD_WIDTH-1:0] CMD_REFRESH = 2'd3;

  // Policy modes; the unused fourth code behaves as auto.
  localparam logic [MODE_WIDTH-1:0] MODE_AUTO   = 2'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_ALWAYS = 2'd1;
  localparam logic [MODE_WIDTH-1:0] MODE_NEVER  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_POLICY_MODE      = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_REFRESH_COOLDOWN = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FAILURE_COOLDOWN = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PAGES_AVAILABLE  = 2'd3;

endpackage

// ===== rtl/hpa_req_if.sv =====
interface hpa_req_if #(
  parameter int unsigned LENGTH_WIDTH = hpa_pkg::LENGTH_WIDTH
);
  logic                               valid;
  logic                               ready;
  logic [hpa_pkg::CMD_WIDTH-1:0]      cmd;
  logic [hpa_pkg::TIME_WIDTH-1:0]     now_time;
  logic [LENGTH_WIDTH-1:0]            length_bytes;
  logic                               sample_valid;
  logic [hpa_pkg::KB_WIDTH-1:0]       sample_page_kb;
  logic [hpa_pkg::BUDGET_WIDTH-1:0]   sample_free_pages;

  modport source (
    output valid, cmd, now_time, length_bytes, sample_valid, sample_page_kb,
           sample_free_pages,
    input  ready
  );
  modport sink (
    input  valid, cmd, now_time, length_bytes, sample_valid, sample_page_kb,
           sample_free_pages,
    output ready
  );
endinterface

// ===== rtl/hpa_resp_if.sv =====
interface hpa_resp_if #(
  parameter int unsigned LENGTH_WIDTH = hpa_pkg::LENGTH_WIDTH
);
  logic                             valid;
  logic                             ready;
  logic                             try_huge;
  logic [LENGTH_WIDTH-1:0]          pages_needed;
  logic [hpa_pkg::BUDGET_WIDTH-1:0] free_pages_left;
  logic [hpa_pkg::PAGE_WIDTH-1:0]   page_size_bytes;

  modport source (
    output valid, try_huge, pages_needed, free_pages_left, page_size_bytes,
    input  ready
  );
  modport sink (
    input  valid, try_huge, pages_needed, free_pages_left, page_size_bytes,
    output ready
  );
endinterface

// ===== rtl/hpa_cfg_if.sv =====
interface hpa_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [hpa_pkg::CFG_INDEX_WIDTH-1:0] index;
  logic [hpa_pkg::CFG_DATA_WIDTH-1:0]  data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ===== rtl/hpa_divider.sv =====
module hpa_divider #(
  parameter int unsigned NUM_WIDTH = hpa_pkg::LENGTH_WIDTH,
  parameter int unsigned DEN_WIDTH = hpa_pkg::PAGE_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [NUM_WIDTH-1:0] num,
  input  logic [DEN_WIDTH-1:0] den,
  output logic                 done,
  output logic [NUM_WIDTH-1:0] quotient
);

  localparam int unsigned CNT_WIDTH = $clog2(NUM_WIDTH + 1);

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_ROUND
  } state_t;

  state_t               state;
  logic [NUM_WIDTH-1:0] num_sh;
  logic [DEN_WIDTH-1:0] den_q;
  logic [DEN_WIDTH-1:0] rem;
  logic [CNT_WIDTH-1:0] cnt;
  logic [DEN_WIDTH:0]   trial;
  logic [DEN_WIDTH:0]   trial_diff;
  logic                 fits;

  // Restoring division, one quotient bit a cycle, most significant first.
  assign trial      = {rem, num_sh[NUM_WIDTH-1]};
  assign fits       = trial >= {1'b0, den_q};
  assign trial_diff = trial - {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) begin
            num_sh <= num;
            den_q  <= den;
            rem    <= '0;
            quotient <= '0;
            cnt    <= CNT_WIDTH'(NUM_WIDTH);
            state  <= D_RUN;
          end
        end
        D_RUN: begin
          num_sh   <= num_sh << 1;
          rem      <= fits ? trial_diff[DEN_WIDTH-1:0] : trial[DEN_WIDTH-1:0];
          quotient <= {quotient[NUM_WIDTH-2:0], fits};
          cnt      <= cnt - 1'b1;
          if (cnt == CNT_WIDTH'(1)) begin
            state <= D_ROUND;
          end
        end
        D_ROUND: begin
          // A nonzero remainder rounds the quotient up.
          if (rem != '0) begin
            quotient <= quotient + 1'b1;
          end
          done  <= 1'b1;
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/huge_page_admission_policy_top.sv =====
// Large-page admission policy. Each input transfer carries one command (query,
// success report, failure report or refresh) and yields exactly one result
// transfer. The block handles one command at a time and holds req.ready low
// while it works. A query in auto mode that is not refused and a success report
// with a nonzero budget run a bit-serial ceiling division of the length by the
// page size, one quotient bit per cycle. Such a query goes through the refresh,
// divider start, divider wait, apply and result states; such a success report
// skips refresh, and other commands go straight to the result state, a refresh
// by way of the refresh state. The result sits in an output register, so a new
// command may be accepted while the previous result waits to be taken.
// Configuration writes are always accepted and must only be issued while the block is idle.
module huge_page_admission_policy_top #(
  parameter int unsigned LENGTH_WIDTH       = hpa_pkg::LENGTH_WIDTH,
  parameter logic [31:0] DEFAULT_PAGE_BYTES = hpa_pkg::DEFAULT_PAGE_BYTES
) (
  input logic      clk,
  input logic      rst,
  hpa_req_if.sink  req,
  hpa_resp_if.source resp,
  hpa_cfg_if.sink  cfg
);

  localparam int unsigned TW = hpa_pkg::TIME_WIDTH;
  localparam int unsigned BW = hpa_pkg::BUDGET_WIDTH;
  localparam int unsigned PW = hpa_pkg::PAGE_WIDTH;
  localparam int unsigned CMP_WIDTH = (LENGTH_WIDTH > BW) ? LENGTH_WIDTH : BW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_REFRESH,
    S_DIV_START,
    S_DIV_WAIT,
    S_APPLY,
    S_RESULT
  } state_t;

  // Configuration registers
  logic [hpa_pkg::MODE_WIDTH-1:0] policy_mode;
  logic [TW-1:0]                  refresh_cooldown;
  logic [TW-1:0]                  failure_cooldown;
  logic                           large_pages_available;

  // Policy state
  logic [PW-1:0] page_bytes;
  logic [BW-1:0] free_budget;
  logic [TW-1:0] last_refresh_time;
  logic [TW-1:0] last_failure_time;

  // Captured command
  logic [hpa_pkg::CMD_WIDTH-1:0] cmd_q;
  logic [TW-1:0]                 now_q;
  logic [LENGTH_WIDTH-1:0]       len_q;
  logic                          sample_valid_q;
  logic [hpa_pkg::KB_WIDTH-1:0]  sample_kb_q;
  logic [BW-1:0]                 sample_free_q;

  state_t                  state;
  logic                    res_try;
  logic [LENGTH_WIDTH-1:0] res_needed;
  logic                    div_start;
  logic [PW-1:0]           div_den;
  logic                    div_done;
  logic [LENGTH_WIDTH-1:0] div_quotient;

  logic                 in_cooldown;
  logic                 refused;
  logic                 refresh_due;
  logic [CMP_WIDTH-1:0] budget_ext;
  logic [CMP_WIDTH-1:0] quot_ext;
  logic [CMP_WIDTH-1:0] budget_diff;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  // A failure stamp of zero reads as no failure recorded.
  assign in_cooldown = (last_failure_time != '0) &&
                       ((now_q - last_failure_time) < failure_cooldown);
  assign refused     = (policy_mode == hpa_pkg::MODE_NEVER) || !large_pages_available ||
                       in_cooldown;
  assign refresh_due = (now_q - last_refresh_time) >= refresh_cooldown;

  assign budget_ext  = CMP_WIDTH'(free_budget);
  assign quot_ext    = CMP_WIDTH'(div_quotient);
  assign budget_diff = budget_ext - quot_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode           <= hpa_pkg::MODE_AUTO;
      refresh_cooldown      <= hpa_pkg::REFRESH_COOLDOWN_RESET;
      failure_cooldown      <= hpa_pkg::FAILURE_COOLDOWN_RESET;
      large_pages_available <= 1'b1;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        hpa_pkg::REG_POLICY_MODE:
          policy_mode <= cfg.data[hpa_pkg::MODE_WIDTH-1:0];
        hpa_pkg::REG_REFRESH_COOLDOWN: refresh_cooldown <= cfg.data;
        hpa_pkg::REG_FAILURE_COOLDOWN: failure_cooldown <= cfg.data;
        hpa_pkg::REG_PAGES_AVAILABLE:  large_pages_available <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      page_bytes        <= PW'(DEFAULT_PAGE_BYTES);
      free_budget       <= '0;
      last_refresh_time <= '0;
      last_failure_time <= '0;
      div_start         <= 1'b0;
      resp.valid        <= 1'b0;
    end else begin
      div_start <= 1'b0;
      // The result state loads a new transfer itself when the old one leaves.
      if (resp.valid && resp.ready && state != S_RESULT) begin
        resp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd_q          <= req.cmd;
            now_q          <= req.now_time;
            len_q          <= req.length_bytes;
            sample_valid_q <= req.sample_valid;
            sample_kb_q    <= req.sample_page_kb;
            sample_free_q  <= req.sample_free_pages;
            res_try        <= 1'b0;
            res_needed     <= '0;
            state          <= S_EVAL;
          end
        end
        S_EVAL: begin
          unique case (cmd_q)
            hpa_pkg::CMD_QUERY: begin
              if (refused) begin
                state <= S_RESULT;
              end else if (policy_mode == hpa_pkg::MODE_ALWAYS) begin
                res_try <= 1'b1;
                state   <= S_RESULT;
              end else begin
                state <= S_REFRESH;
              end
            end
            hpa_pkg::CMD_SUCCESS: begin
              last_failure_time <= '0;
              if (free_budget != '0 && page_bytes != '0) begin
                state <= S_DIV_START;
              end else begin
                state <= S_RESULT;
              end
            end
            hpa_pkg::CMD_FAILURE: begin
              last_failure_time <= now_q;
              free_budget       <= '0;
              state             <= S_RESULT;
            end
            hpa_pkg::CMD_REFRESH: state <= S_REFRESH;
            default: state <= S_RESULT;
          endcase
        end
        S_REFRESH: begin
          if (refresh_due) begin
            if (sample_valid_q) begin
              if (sample_kb_q != '0) begin
                page_bytes <= {sample_kb_q, {hpa_pkg::KB_SHIFT{1'b0}}};
              end
              free_budget <= sample_free_q;
            end
            last_refresh_time <= now_q;
          end
          state <= (cmd_q == hpa_pkg::CMD_QUERY) ? S_DIV_START : S_RESULT;
        end
        S_DIV_START: begin
          div_den   <= (page_bytes != '0) ? page_bytes : PW'(DEFAULT_PAGE_BYTES);
          div_start <= 1'b1;
          state     <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          res_needed <= div_quotient;
          if (cmd_q == hpa_pkg::CMD_QUERY) begin
            res_try <= budget_ext >= quot_ext;
          end else if (quot_ext <= budget_ext) begin
            free_budget <= budget_diff[BW-1:0];
          end else begin
            free_budget <= '0;
          end
          state <= S_RESULT;
        end
        S_RESULT: begin
          // Wait until the output register is free or being emptied.
          if (!resp.valid || resp.ready) begin
            resp.valid           <= 1'b1;
            resp.try_huge        <= res_try;
            resp.pages_needed    <= res_needed;
            resp.free_pages_left <= free_budget;
            resp.page_size_bytes <= page_bytes;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  hpa_divider #(
    .NUM_WIDTH (LENGTH_WIDTH),
    .DEN_WIDTH (PW)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (len_q),
    .den      (div_den),
    .done     (div_done),
    .quotient (div_quotient)
  );

endmodule

// ===== rtl/hpa_checker.sv =====
module hpa_checker #(
  parameter int unsigned LENGTH_WIDTH = hpa_pkg::LENGTH_WIDTH
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             req_valid,
  input logic                             req_ready,
  input logic                             resp_valid,
  input logic                             resp_ready,
  input logic                             try_huge,
  input logic [LENGTH_WIDTH-1:0]          pages_needed,
  input logic [hpa_pkg::BUDGET_WIDTH-1:0] free_pages_left
);

  localparam int unsigned CMP_WIDTH =
    (LENGTH_WIDTH > hpa_pkg::BUDGET_WIDTH) ? LENGTH_WIDTH : hpa_pkg::BUDGET_WIDTH;

  // A result that is not taken stays offered with the same contents.
  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp_ready |=> resp_valid && $stable(pages_needed) &&
                                  $stable(free_pages_left) && $stable(try_huge))
    else $error("result changed or vanished before its transfer");

  // The block works on one command at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("new command accepted while one is in progress");

  // A granted query never needs more pages than the budget it reports.
  a_grant_within_budget: assert property (@(posedge clk) disable iff (rst)
    resp_valid && try_huge |->
      CMP_WIDTH'(pages_needed) <= CMP_WIDTH'(free_pages_left))
    else $error("large pages granted beyond the free budget");

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !resp_valid)
    else $error("result offered straight after reset");

endmodule

bind huge_page_admission_policy_top hpa_checker #(
  .LENGTH_WIDTH (LENGTH_WIDTH)
) u_hpa_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .resp_valid      (resp.valid),
  .resp_ready      (resp.ready),
  .try_huge        (resp.try_huge),
  .pages_needed    (resp.pages_needed),
  .free_pages_left (resp.free_pages_left)
);
